@@ src/selective_ack_scoreboard_core_assert.svh @@
// Assertion macros for the selective ack scoreboard.
// All properties sample on the rising edge of clock and are disabled in reset.
`ifndef SELECTIVE_ACK_SCOREBOARD_CORE_ASSERT_SVH
`define SELECTIVE_ACK_SCOREBOARD_CORE_ASSERT_SVH

// Same-cycle implication
`define SASC_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scoreboard assertion failed");

// Next-cycle implication
`define SASC_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scoreboard assertion failed");

`endif

@@ src/sasc_pkg.sv @@
`timescale 1ns / 1ps
package sasc_pkg;

   // Request opcodes (req_tuser)
   localparam logic OP_SEND = 1'b0;
   localparam logic OP_ACK  = 1'b1;

   // Response status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_REJECTED = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;

   // Early mask covers sequences expected+1 .. expected+1+EARLY_SPAN_MAX
   localparam logic [15:0] EARLY_SPAN_MAX = 16'h001F;

   // Payload widths
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 72;
   localparam logic [6:0] COUNT_SAT = 7'd63;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_GROUP,
      ST_PUBLISH
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;   // latch request transaction
      logic evaluate;  // update table, form hit vector
      logic group;     // per-byte population counts
      logic publish;   // load response register
   } cmd_type;

   // Population count of one byte
   function automatic logic [3:0] popcount8(input logic [7:0] bits);
      logic [3:0] acc;
      acc = 4'd0;
      for (int i = 0; i < 8; i++) begin
         acc = acc + {3'd0, bits[i]};
      end
      return acc;
   endfunction

endpackage

@@ src/selective_ack_scoreboard_core.sv @@
`timescale 1ns / 1ps
// Selective ack scoreboard core.
// Request channel (req_*): tuser carries the opcode, send or ack; tdata carries
// the peer's expected sequence and the 32-bit early mask used by acks.
// A send claims the lowest free slot and is given the next sequence number, or
// returns table full. An ack frees every slot before the expected sequence and
// every slot whose sequence the early mask marks, unless it acks unsent data.
// Response channel (rsp_*): one transaction per request with status, assigned
// sequence, freed slot mask, freed count and the remote expected head.
// Timing: a request is taken in the idle state; the table is updated in the
// next cycle, the freed count is then formed by a registered byte-wise count
// tree, and rsp_tvalid rises once the publish state loads the response
// register. Requests are taken only in idle, so the block handles one
// transaction at a time, set by this four-state controller sequence.
// The response sits in an output register; a new request is taken while it
// waits. If the receiver stalls, the following result waits in the publish
// state, and further requests are held off until the register is drained.
// Reset (synchronous) empties the table and zeroes the next and remote
// sequence numbers; the slot sequence store itself is not cleared.
module selective_ack_scoreboard_core #(
   parameter int SLOTS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // expected_seq[15:0], early_mask[47:16]
   input  logic        req_tuser,  // opcode[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], assigned_seq[17:2], freed_slots[49:18], freed_count[55:50],
   // remote_head[71:56]
   output logic [71:0] rsp_tdata
);
   import sasc_pkg::*;

   cmd_type cmd;

   // Sequencer
   sasc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // Table and response datapath
   sasc_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_opcode (req_tuser),
      .req_data   (req_tdata),
      .rsp_data   (rsp_tdata)
   );

endmodule

@@ src/sasc_ctrl.sv @@
`timescale 1ns / 1ps
module sasc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output sasc_pkg::cmd_type cmd
);
   import sasc_pkg::*;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   // State and response-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      out_valid_in = out_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.evaluate = 1'b1;
            state_in     = ST_GROUP;
         end
         ST_GROUP: begin
            cmd.group = 1'b1;
            state_in  = ST_PUBLISH;
         end
         ST_PUBLISH: begin
            // wait until the response register is free or being drained
            if (!out_valid_ff || rsp_tready) begin
               cmd.publish  = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = out_valid_ff;

endmodule

@@ src/sasc_datapath.sv @@
`timescale 1ns / 1ps
module sasc_datapath #(
   parameter int SLOTS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sasc_pkg::cmd_type                   cmd,
   input  logic                                req_opcode,
   input  logic [sasc_pkg::REQ_DATA_W-1:0]     req_data,
   output logic [sasc_pkg::RSP_DATA_W-1:0]     rsp_data
);
   import sasc_pkg::*;

   localparam int GROUPS = (SLOTS + 7) / 8;
   localparam int CNT_W  = $clog2(SLOTS + 1);

   // Table state
   logic [SLOTS-1:0] slot_valid_ff, slot_valid_in;
   logic [15:0]      slot_seq_ff [SLOTS];
   logic [15:0]      next_seq_ff;
   logic [15:0]      remote_ff;

   // Captured request
   logic        op_ff;
   logic [15:0] exp_ff;
   logic [31:0] mask_ff;

   // Evaluation results
   logic [SLOTS-1:0] hit_ff, hit_in;
   logic [1:0]       status_ff;
   logic [15:0]      assigned_ff;
   logic [3:0]       group_cnt_ff [GROUPS];

   // Response register
   logic [1:0]  out_status_ff;
   logic [15:0] out_assigned_ff;
   logic [31:0] out_freed_ff;
   logic [5:0]  out_count_ff;
   logic [15:0] out_remote_ff;

   // Combinational terms
   logic [SLOTS-1:0]   free_onehot;
   logic               table_full;
   logic               ack_reject;
   logic [15:0]        head_dist;
   logic [GROUPS*8-1:0] hit_pad;
   logic [CNT_W-1:0]   total;
   logic [6:0]         total_ext;
   logic [31:0]        freed_bits;

   // Lowest free slot and per-slot ack match
   always_comb begin
      logic [15:0] seq_gap;
      logic [15:0] k;
      free_onehot = ~slot_valid_ff & (slot_valid_ff + {{(SLOTS-1){1'b0}}, 1'b1});
      table_full  = &slot_valid_ff;
      seq_gap     = next_seq_ff - exp_ff;
      ack_reject  = seq_gap[15];
      head_dist   = exp_ff - remote_ff;
      for (int i = 0; i < SLOTS; i++) begin
         k = slot_seq_ff[i] - exp_ff - 16'd1;
         seq_gap = slot_seq_ff[i] - exp_ff;
         hit_in[i] = slot_valid_ff[i] &&
                     (seq_gap[15] || (k <= EARLY_SPAN_MAX && mask_ff[k[4:0]]));
      end
      slot_valid_in = slot_valid_ff;
      if (op_ff == OP_SEND) begin
         if (!table_full) begin
            slot_valid_in = slot_valid_ff | free_onehot;
         end
      end else if (!ack_reject) begin
         slot_valid_in = slot_valid_ff & ~hit_in;
      end
   end

   // Control-side table state
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         next_seq_ff   <= 16'd0;
         remote_ff     <= 16'd0;
      end else if (cmd.evaluate) begin
         slot_valid_ff <= slot_valid_in;
         if (op_ff == OP_SEND) begin
            if (!table_full) begin
               next_seq_ff <= next_seq_ff + 16'd1;
            end
         end else if (!ack_reject && head_dist != 16'd0 && !head_dist[15]) begin
            remote_ff <= exp_ff;
         end
      end
   end

   // Slot sequence store, written only into the claimed slot
   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOTS; i++) begin
         if (cmd.evaluate && op_ff == OP_SEND && free_onehot[i]) begin
            slot_seq_ff[i] <= next_seq_ff;
         end
      end
   end

   // Request capture and evaluation results
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_opcode;
         exp_ff  <= req_data[15:0];
         mask_ff <= req_data[47:16];
      end
      if (cmd.evaluate) begin
         hit_ff      <= '0;
         assigned_ff <= 16'd0;
         status_ff   <= STATUS_OK;
         if (op_ff == OP_SEND) begin
            if (table_full) begin
               status_ff <= STATUS_FULL;
            end else begin
               assigned_ff <= next_seq_ff;
            end
         end else if (ack_reject) begin
            status_ff <= STATUS_REJECTED;
         end else begin
            hit_ff <= hit_in;
         end
      end
   end

   // First level of the count tree: one byte per group
   always_comb begin
      hit_pad = '0;
      hit_pad[SLOTS-1:0] = hit_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.group) begin
         for (int g = 0; g < GROUPS; g++) begin
            group_cnt_ff[g] <= popcount8(hit_pad[g*8 +: 8]);
         end
      end
   end

   // Second level: sum groups, saturate, report low 32 slots
   always_comb begin
      total = '0;
      for (int g = 0; g < GROUPS; g++) begin
         total = total + CNT_W'(group_cnt_ff[g]);
      end
      total_ext  = 7'(total);
      freed_bits = '0;
      for (int i = 0; i < 32; i++) begin
         if (i < SLOTS) begin
            freed_bits[i] = hit_pad[i];
         end
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         out_status_ff   <= status_ff;
         out_assigned_ff <= assigned_ff;
         out_freed_ff    <= freed_bits;
         out_count_ff    <= (total_ext > COUNT_SAT) ? 6'(COUNT_SAT) : total_ext[5:0];
         out_remote_ff   <= remote_ff;
      end
   end

   assign rsp_data = {out_remote_ff, out_count_ff, out_freed_ff,
                      out_assigned_ff, out_status_ff};

endmodule

@@ src/sasc_checker.sv @@
`timescale 1ns / 1ps
`include "selective_ack_scoreboard_core_assert.svh"
module sasc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);
   import sasc_pkg::*;

   // One request at a time: ready drops after each accepted transaction
   `SASC_ASSERT_NXT(a_one_at_a_time, req_tvalid && req_tready, !req_tready)

   // No response rises while an accepted request is in the evaluate and group states
   `SASC_ASSERT_NXT(a_min_latency, req_tvalid && req_tready, !$rose(rsp_tvalid) ##1 !$rose(rsp_tvalid))

   // A stalled response holds its payload
   `SASC_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // Refused transactions free nothing and assign nothing
   `SASC_ASSERT_IMP(a_refused_clean, rsp_tvalid && rsp_tdata[1:0] != STATUS_OK, rsp_tdata[55:2] == 54'd0)

endmodule

bind selective_ack_scoreboard_core sasc_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
   import sasc_pkg::*;

   localparam int TABLE_SLOTS = 32;
   localparam int unsigned CYCLE_LIMIT = 200_000;
   localparam int PRINT_LIMIT = 40;

   // One response transaction, unpacked
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] assigned_seq;
      logic [31:0] freed_slots;
      logic [5:0]  freed_count;
      logic [15:0] remote_head;
   } ack_outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // expected_seq[15:0], early_mask[47:16]
   logic        req_tuser = 1'b0; // opcode[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // status[1:0], assigned_seq[17:2], freed_slots[49:18], freed_count[55:50],
   // remote_head[71:56]
   logic [71:0] rsp_tdata;

   // Shadow copy of the scoreboard table
   logic        slot_busy [TABLE_SLOTS];
   logic [15:0] slot_seq [TABLE_SLOTS];
   logic [15:0] next_seq = '0;
   logic [15:0] remote_head = '0;

   ack_outcome_type pending_results [$];
   ack_outcome_type due_result;

   int unsigned cycle_count = 0;
   int error_count = 0;
   int req_gap_max = 9;
   int rsp_stall_max = 9;
   int sends_done = 0;
   int full_refusals = 0;
   int acks_done = 0;
   int acks_rejected = 0;
   int slots_released = 0;

   selective_ack_scoreboard_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_results.size());
         $display("selective_ack_scoreboard_core verification failed");
         $finish;
      end
   end

   // a is before b when bit 15 of the 16-bit difference is set
   function automatic logic seq_is_before(input logic [15:0] a, input logic [15:0] b);
      logic [15:0] diff;
      diff = a - b;
      return diff[15];
   endfunction

   // Apply one request transaction to the shadow table and form its response
   function automatic ack_outcome_type advance_window(input logic op,
                                                      input logic [15:0] exp_seq,
                                                      input logic [31:0] mask);
      ack_outcome_type res;
      int slot;
      logic [15:0] offset;
      logic hit;
      res = '0;
      slot = -1;
      if (op == OP_SEND) begin
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (!slot_busy[i] && slot < 0) slot = i;
         end
         if (slot < 0) begin
            res.status = STATUS_FULL;
         end else begin
            slot_busy[slot] = 1'b1;
            slot_seq[slot] = next_seq;
            res.assigned_seq = next_seq;
            next_seq = next_seq + 16'd1;
         end
      end else if (seq_is_before(next_seq, exp_seq)) begin
         res.status = STATUS_REJECTED;
      end else begin
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (slot_busy[i]) begin
               offset = slot_seq[i] - exp_seq - 16'd1;
               hit = seq_is_before(slot_seq[i], exp_seq) ||
                     (offset <= EARLY_SPAN_MAX && mask[offset[4:0]]);
               if (hit) begin
                  slot_busy[i] = 1'b0;
                  res.freed_slots[i] = 1'b1;
                  res.freed_count = res.freed_count + 6'd1;
               end
            end
         end
         // remote head only moves forward
         offset = exp_seq - remote_head;
         if (offset != 16'd0 && !offset[15]) remote_head = exp_seq;
      end
      res.remote_head = remote_head;
      return res;
   endfunction

   function automatic int free_slot_count();
      int n;
      n = 0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         if (!slot_busy[i]) n++;
      end
      return n;
   endfunction

   // Sequence of the longest-outstanding packet, or next_seq on an empty table
   function automatic logic [15:0] oldest_outstanding();
      logic [15:0] oldest;
      logic [15:0] span;
      oldest = next_seq;
      span = '0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         if (slot_busy[i] && (next_seq - slot_seq[i]) > span) begin
            span = next_seq - slot_seq[i];
            oldest = slot_seq[i];
         end
      end
      return oldest;
   endfunction

   function automatic logic [31:0] pick_mask();
      case ($urandom_range(0, 4))
         0: return 32'hFFFF_FFFF;
         1: return 32'h0;
         2: return 32'h1 << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("cycle %0d: %s mismatch, got 0x%0h expected 0x%0h",
                  cycle_count, what, got, want);
   endtask

   // Send one request transaction; valid stays up when the next one follows at once
   task automatic send_item(input logic op, input logic [15:0] exp_seq,
                            input logic [31:0] mask);
      int gap;
      ack_outcome_type res;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {mask, exp_seq};
      do @(posedge clock); while (!req_tready);
      res = advance_window(op, exp_seq, mask);
      pending_results.insert(pending_results.size(), res);
      if (op == OP_SEND) begin
         sends_done++;
         if (res.status == STATUS_FULL) full_refusals++;
      end else begin
         acks_done++;
         if (res.status == STATUS_REJECTED) acks_rejected++;
         slots_released += res.freed_count;
      end
   endtask

   task automatic send_packet();
      send_item(OP_SEND, 16'($urandom), $urandom);
   endtask

   // Response receiver with random back-pressure
   initial begin
      int stall;
      wait (!reset);
      forever begin
         stall = $urandom_range(0, rsp_stall_max);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Response checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected response", rsp_tdata[31:0], 32'h0);
         end else begin
            due_result = pending_results.pop_front();
            if (rsp_tdata[1:0] != due_result.status)
               report_mismatch("status", rsp_tdata[1:0], due_result.status);
            if (rsp_tdata[17:2] != due_result.assigned_seq)
               report_mismatch("assigned_seq", rsp_tdata[17:2], due_result.assigned_seq);
            if (rsp_tdata[49:18] != due_result.freed_slots)
               report_mismatch("freed_slots", rsp_tdata[49:18], due_result.freed_slots);
            if (rsp_tdata[55:50] != due_result.freed_count)
               report_mismatch("freed_count", rsp_tdata[55:50], due_result.freed_count);
            if (rsp_tdata[71:56] != due_result.remote_head)
               report_mismatch("remote_head", rsp_tdata[71:56], due_result.remote_head);
         end
      end
   end

   // Acks on an empty and a sparse table, rejection boundary, head not moving back
   task automatic test_basic_acks();
      send_item(OP_ACK, 16'h0000, 32'h0);
      send_item(OP_ACK, 16'h0001, 32'hFFFF_FFFF);
      repeat (3) send_packet();
      // exactly half the sequence space ahead is still rejected
      send_item(OP_ACK, next_seq + 16'h8000, 32'hFFFF_FFFF);
      send_item(OP_ACK, next_seq + 16'h8001, 32'hFFFF_FFFF);
      send_item(OP_ACK, 16'hFFFF, 32'h0);
      // slot equal to expected stays, mask bit 0 frees expected+1
      send_item(OP_ACK, 16'h0000, 32'h0000_0001);
      send_item(OP_ACK, next_seq, 32'hFFFF_FFFF);
      send_item(OP_ACK, next_seq - 16'd1, 32'h0);
   endtask

   // Fill the table, refuse when full, mask span ends one short of 33
   task automatic test_table_full();
      while (free_slot_count() > 0) send_packet();
      repeat (2) send_packet();
      send_item(OP_ACK, oldest_outstanding() - 16'd2, 32'hFFFF_FFFF);
      while (free_slot_count() > 0) send_packet();
      send_packet();
      // releases all 32 slots at once
      send_item(OP_ACK, next_seq, 32'h0);
   endtask

   // First and last mask bit, slot exactly at expected
   task automatic test_early_mask_edges();
      logic [15:0] base;
      base = next_seq;
      while (free_slot_count() > 0) send_packet();
      send_item(OP_ACK, base - 16'd1, 32'h8000_0001);
      send_item(OP_ACK, base + 16'd5, 32'h0);
      send_item(OP_ACK, base + 16'd5, 32'h0000_0001);
      send_item(OP_ACK, next_seq, 32'h0);
   endtask

   // Mostly well-formed traffic with random content, some noise acks
   task automatic test_random_traffic(input int items);
      int send_pct;
      int pick;
      logic [15:0] oldest;
      send_pct = 50;
      for (int n = 0; n < items; n++) begin
         if (n % 100 == 0) begin
            case ($urandom_range(0, 2))
               0: send_pct = 30;
               1: send_pct = 50;
               default: send_pct = 75;
            endcase
         end
         pick = $urandom_range(0, 99);
         if (pick < send_pct) begin
            send_packet();
         end else if (pick < send_pct + (100 - send_pct) * 4 / 5) begin
            oldest = oldest_outstanding();
            send_item(OP_ACK, oldest + 16'($urandom_range(0, int'(next_seq - oldest))),
                      pick_mask());
         end else begin
            case ($urandom_range(0, 2))
               0: send_item(OP_ACK, 16'($urandom), $urandom);
               1: send_item(OP_ACK, next_seq + 16'($urandom_range(1, 40)), pick_mask());
               default: send_item(OP_ACK, next_seq + 16'h8000, pick_mask());
            endcase
         end
      end
   endtask

   initial begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         slot_busy[i] = 1'b0;
         slot_seq[i] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_basic_acks();
      test_table_full();
      test_early_mask_edges();
      test_random_traffic(1700);

      // drain
      req_tvalid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (8) @(posedge clock);

      $display("covered %0d sends (%0d refused on a full table), %0d acks (%0d rejected)",
               sends_done, full_refusals, acks_done, acks_rejected);
      $display("%0d slots released, %0d mismatches in %0d cycles",
               slots_released, error_count, cycle_count);
      if (error_count == 0)
         $display("selective_ack_scoreboard_core verification clean");
      else
         $display("selective_ack_scoreboard_core verification failed");
      $finish;
   end

endmodule
